FILE: rtl/mxq_pkg.sv
// ============================================================================
// mxq_pkg
// Shared types and constants for the min-extract queue.
// ============================================================================
`default_nettype none

package mxq_pkg;

    localparam int unsigned DATA_W       = 32;
    localparam int unsigned CMD_W        = 2;
    localparam int unsigned CAPACITY_DEF = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // Status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PEEK  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_SH_RD = 5'b01000,
        ST_SH_WR = 5'b10000
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/min_extract_queue.sv
// ============================================================================
// min_extract_queue
// Bounded store of signed words in arrival order with insert, peek-oldest and
// remove-minimum commands, run by a small sequencer over one RAM.
// ============================================================================
//
//  channel   | signals                                   | transfer
//  ----------+-------------------------------------------+---------------------------
//  command   | start, busy, i_cmd, i_value               | start && !busy at clk edge
//  result    | o_strobe, o_status, o_result_value,       | one cycle while o_strobe
//            | o_fill_count                              |
//
//  Insert and every error answer: the result strobes the cycle after the
//  transaction and busy stays low. Peek takes the RAM read of the oldest
//  entry in ST_PEEK, then registers the result. Remove runs a scan of one
//  RAM read per entry through the shared signed comparator, then a compaction
//  that moves one entry per ST_SH_RD/ST_SH_WR pair through the single RAM port pair.
//  Reset clears the fill count and the sequencer; the RAM needs no clearing,
//  since only entries below the fill count are ever used.
//  The receiver cannot stall: each result is shown for exactly one cycle.
// ============================================================================
`default_nettype none

module min_extract_queue #(
    parameter int unsigned CAPACITY = mxq_pkg::CAPACITY_DEF,
    localparam int unsigned AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // command channel
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [mxq_pkg::CMD_W-1:0]         i_cmd,
    input  wire logic signed [mxq_pkg::DATA_W-1:0] i_value,
    // result channel
    output logic                                   o_strobe,
    output logic                                   o_status,
    output logic signed [mxq_pkg::DATA_W-1:0]      o_result_value,
    output logic [CW-1:0]                          o_fill_count
);

    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    mxq_pkg::t_state r_state, n_state;

    logic [CW-1:0]                 r_count, n_count;
    logic [AW-1:0]                 r_idx, n_idx;    // scan index / compaction destination
    logic [AW-1:0]                 r_pos, n_pos;    // index of current minimum
    logic [mxq_pkg::DATA_W-1:0]    r_min, n_min;    // current minimum
    logic                          r_strobe, n_strobe;
    logic                          r_status, n_status;
    logic [mxq_pkg::DATA_W-1:0]    r_value, n_value;

    // RAM port signals
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [mxq_pkg::DATA_W-1:0]    ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [mxq_pkg::DATA_W-1:0]    ram_rdata;

    // Shared compare unit: running minimum including the word now read.
    logic [CW-1:0]                 last;
    logic                          take_new;
    logic [mxq_pkg::DATA_W-1:0]    min_now;
    logic [AW-1:0]                 pos_now;

    assign last     = r_count - 1'b1;
    assign take_new = (r_idx == '0) || ($signed(ram_rdata) < $signed(r_min));
    assign min_now  = take_new ? ram_rdata : r_min;
    assign pos_now  = take_new ? r_idx : r_pos;

    mxq_ram #(
        .WIDTH (mxq_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_min     = r_min;
        n_strobe  = 1'b0;
        n_status  = r_status;
        n_value   = r_value;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = ram_rdata;
        ram_raddr = AW'(r_idx + 1'b1);

        case (r_state)
            mxq_pkg::ST_IDLE: begin
                ram_raddr = '0;     // oldest entry, for peek and for the scan start
                if (start) begin
                    case (i_cmd)
                        mxq_pkg::CMD_INSERT: begin
                            n_strobe = 1'b1;
                            n_value  = '0;
                            if (r_count >= CAP_CNT) begin
                                n_status = mxq_pkg::STATUS_ERR;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(r_count);
                                ram_wdata = i_value;
                                n_count   = r_count + 1'b1;
                                n_status  = mxq_pkg::STATUS_OK;
                            end
                        end
                        mxq_pkg::CMD_PEEK: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_status = mxq_pkg::STATUS_ERR;
                                n_value  = '0;
                            end else begin
                                n_state = mxq_pkg::ST_PEEK;
                            end
                        end
                        mxq_pkg::CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_status = mxq_pkg::STATUS_ERR;
                                n_value  = '0;
                            end else begin
                                n_idx   = '0;
                                n_state = mxq_pkg::ST_SCAN;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_status = mxq_pkg::STATUS_ERR;
                            n_value  = '0;
                        end
                    endcase
                end
            end

            mxq_pkg::ST_PEEK: begin
                n_strobe = 1'b1;
                n_status = mxq_pkg::STATUS_OK;
                n_value  = ram_rdata;
                n_state  = mxq_pkg::ST_IDLE;
            end

            mxq_pkg::ST_SCAN: begin
                // ram_rdata holds entry r_idx; the next address is already issued
                n_min = min_now;
                n_pos = pos_now;
                if (CW'(r_idx) == last) begin
                    if (CW'(pos_now) == last) begin
                        // minimum is the newest entry: nothing to compact
                        n_strobe = 1'b1;
                        n_status = mxq_pkg::STATUS_OK;
                        n_value  = min_now;
                        n_count  = last;
                        n_state  = mxq_pkg::ST_IDLE;
                    end else begin
                        n_idx   = pos_now;
                        n_state = mxq_pkg::ST_SH_RD;
                    end
                end else begin
                    n_idx = AW'(r_idx + 1'b1);
                end
            end

            mxq_pkg::ST_SH_RD: begin
                // read entry r_idx+1 (default read address)
                n_state = mxq_pkg::ST_SH_WR;
            end

            mxq_pkg::ST_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                if ((CW'(r_idx) + 1'b1) == last) begin
                    n_strobe = 1'b1;
                    n_status = mxq_pkg::STATUS_OK;
                    n_value  = r_min;
                    n_count  = last;
                    n_state  = mxq_pkg::ST_IDLE;
                end else begin
                    n_idx   = AW'(r_idx + 1'b1);
                    n_state = mxq_pkg::ST_SH_RD;
                end
            end

            default: begin
                n_state = mxq_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mxq_pkg::ST_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_min    <= n_min;
        r_status <= n_status;
        r_value  <= n_value;
    end

    assign busy           = (r_state != mxq_pkg::ST_IDLE);
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_result_value = r_value;
    assign o_fill_count   = r_count;

endmodule

`default_nettype wire

FILE: rtl/mxq_ram.sv
// ============================================================================
// mxq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module mxq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/mxq_checker.sv
// ============================================================================
// mxq_checker
// Port-level checks for the min-extract queue, bound to the top level.
// ============================================================================
`default_nettype none

module mxq_checker #(
    parameter int unsigned CAPACITY = mxq_pkg::CAPACITY_DEF,
    localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic [mxq_pkg::CMD_W-1:0]         i_cmd,
    input wire logic                              o_strobe,
    input wire logic                              o_status,
    input wire logic signed [mxq_pkg::DATA_W-1:0] o_result_value,
    input wire logic [CW-1:0]                     o_fill_count
);

    // fill count never passes capacity while a result is shown
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_fill_count <= CW'(CAPACITY)))
        else $error("fill count above capacity");

    // an insert transaction is answered in the next cycle
    a_insert_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd == mxq_pkg::CMD_INSERT)) |=> o_strobe)
        else $error("insert not answered in one cycle");

    // error answers carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == mxq_pkg::STATUS_ERR)) |-> (o_result_value == '0))
        else $error("error result with nonzero value");

    // a result is shown only once the sequencer is free again
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while busy");

endmodule

bind min_extract_queue mxq_checker #(
    .CAPACITY (CAPACITY)
) u_mxq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_cmd          (i_cmd),
    .o_strobe       (o_strobe),
    .o_status       (o_status),
    .o_result_value (o_result_value),
    .o_fill_count   (o_fill_count)
);

`default_nettype wire
